@@ src/gbf_pkg.sv @@
// ----------------------------------------------------------------------------
// Boundary friction projection package
// Shared types, constants and arithmetic helpers for the boundary velocity
// pipeline and its checker.
// ----------------------------------------------------------------------------
package gbf_pkg;

  localparam logic signed [31:0] PHI_HI = 32'sd65536;
  localparam logic signed [31:0] PHI_LO = -32'sd196608;

  localparam int SQRT_STAGES = 32;
  localparam int LATENCY     = 68;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [67:0] wide_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [16:0] q;
  } div_t;

  function automatic s32_t sat32(input wide_t x);
    if (x > 68'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -68'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic wide_t rnd16(input wide_t x);
    return (x + 68'sd32768) >>> 16;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [63:0] bitv);
    sqrt_t       o;
    logic [63:0] trial;
    trial = s.r + bitv;
    if (s.x >= trial) begin
      o.x = s.x - trial;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_step(input div_t s, input logic nb, input logic [31:0] d);
    div_t        o;
    logic [32:0] tmp;
    tmp = {s.rem, nb};
    if (tmp >= {1'b0, d}) begin
      o.rem = 32'(tmp - {1'b0, d});
      o.q   = {s.q[15:0], 1'b1};
    end else begin
      o.rem = tmp[31:0];
      o.q   = {s.q[15:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ src/grid_boundary_friction_projection_core.sv @@
// ----------------------------------------------------------------------------
// Grid boundary friction projection core
// Applies the moving level-set boundary rule with Coulomb friction to one
// grid cell velocity per transfer, in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// The core is a fixed pipeline that takes one cell on every clock cycle and
// never raises busy. Each result is on the output ports while done_o is high
// for one cycle, and the receiver cannot hold it off. The latency is set by
// the tangent length square root, which resolves one root bit per stage over
// 32 stages, and by the tangent normalization dividers, which resolve one
// quotient bit per stage over 17 stages. The friction coefficient register
// is always ready and must be written only while no cell is in flight.
module grid_boundary_friction_projection_core #(
  parameter int DIMENSIONS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [17:0] norm_x_i,
  input  logic signed [17:0] norm_y_i,
  input  logic signed [17:0] norm_z_i,
  input  logic signed [31:0] phi_i,
  input  logic signed [31:0] phi_rate_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic signed [21:0] cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic signed [31:0] out_vel_z_o,
  output logic               touched_o
);

  localparam int Lat = gbf_pkg::LATENCY;
  localparam int SideLen = 59;

  typedef struct packed {
    logic [2:0][31:0] v;
    logic [2:0][31:0] b;
    logic [2:0][31:0] alt;
    logic [2:0][31:0] t;
    logic [2:0][34:0] np;
    logic [31:0]      lim;
    logic             fric;
    logic             touched;
  } side_t;

  logic signed [21:0] mu_q;
  logic [Lat-1:0]     vld_q;

  logic signed [31:0] vel_q [0:7][3];
  logic signed [17:0] n_q [0:6][3];
  logic signed [31:0] phi_q, rate_q;
  logic               skip_q [1:7];
  logic               phipos_q [1:7];
  logic               phineg_q [1:7];
  logic signed [49:0] prod_b_q [3];
  logic signed [31:0] b_q [2:7][3];
  logic signed [31:0] v_q [3:7][3];
  logic signed [49:0] pv_q [3];
  logic signed [31:0] vn_q;
  logic signed [49:0] pnvn_q [3];
  logic signed [31:0] press_q, posvn_q;
  logic signed [31:0] qnvn_q [3];
  logic signed [49:0] pns_q [3];
  logic signed [49:0] pnp_q [3];
  logic signed [53:0] plim_q;

  side_t              side_d;
  side_t              side_q [0:SideLen-1];

  logic signed [63:0] sq_q [3];
  logic [63:0]        len2_q;
  gbf_pkg::sqrt_t     sq_in [gbf_pkg::SQRT_STAGES];
  gbf_pkg::sqrt_t     sqs_q [gbf_pkg::SQRT_STAGES];

  gbf_pkg::div_t      div_d [3];
  logic [16:0]        nlo_d [3];
  logic [2:0]         negu_d;
  gbf_pkg::div_t      dv_q [0:17][3];
  logic [16:0]        nlo_q [0:16][3];
  logic [31:0]        d_q [0:16];
  logic [2:0]         negu_q [0:17];
  logic               z_q [0:17];

  logic signed [17:0] u_q [0:3][3];
  logic signed [49:0] puv_q [3];
  logic signed [31:0] tv_q, fr_q;
  logic signed [49:0] pufr_q [3];
  logic signed [31:0] vnew_q [3];
  logic signed [31:0] out_q [3];
  logic               touched_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign done_o      = vld_q[Lat-1];
  assign out_vel_x_o = out_q[0];
  assign out_vel_y_o = out_q[1];
  assign out_vel_z_o = out_q[2];
  assign touched_o   = touched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q  <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mu_q <= cfg_data_i;
      end
      vld_q <= {vld_q[Lat-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    vel_q[0][0] <= vel_x_i;
    vel_q[0][1] <= vel_y_i;
    vel_q[0][2] <= (DIMENSIONS > 2) ? vel_z_i : 32'sd0;
    n_q[0][0]   <= norm_x_i;
    n_q[0][1]   <= norm_y_i;
    n_q[0][2]   <= (DIMENSIONS > 2) ? norm_z_i : 18'sd0;
    phi_q       <= phi_i;
    rate_q      <= phi_rate_i;
    for (int j = 1; j < 8; j++) vel_q[j] <= vel_q[j-1];
    for (int j = 1; j < 7; j++) n_q[j] <= n_q[j-1];

    skip_q[1]   <= (phi_q > gbf_pkg::PHI_HI) || (phi_q < gbf_pkg::PHI_LO);
    phipos_q[1] <= phi_q > 32'sd0;
    phineg_q[1] <= phi_q < 32'sd0;
    for (int j = 2; j < 8; j++) begin
      skip_q[j]   <= skip_q[j-1];
      phipos_q[j] <= phipos_q[j-1];
      phineg_q[j] <= phineg_q[j-1];
    end

    for (int i = 0; i < 3; i++) begin
      prod_b_q[i] <= rate_q * n_q[0][i];
      b_q[2][i]   <= gbf_pkg::sat32(gbf_pkg::rnd16(68'(prod_b_q[i])));
      v_q[3][i]   <= gbf_pkg::sat32(68'(vel_q[2][i]) - 68'(b_q[2][i]));
      pv_q[i]     <= v_q[3][i] * n_q[3][i];
      pnvn_q[i]   <= vn_q * n_q[5][i];
      qnvn_q[i]   <= gbf_pkg::sat32(gbf_pkg::rnd16(68'(pnvn_q[i])));
      pns_q[i]    <= posvn_q * n_q[6][i];
      pnp_q[i]    <= press_q * n_q[6][i];
    end
    for (int j = 3; j < 8; j++) b_q[j] <= b_q[j-1];
    for (int j = 4; j < 8; j++) v_q[j] <= v_q[j-1];

    vn_q    <= gbf_pkg::sat32(gbf_pkg::rnd16(68'(pv_q[0]) + 68'(pv_q[1]) + 68'(pv_q[2])));
    press_q <= (vn_q < 32'sd0) ? gbf_pkg::sat32(-68'(vn_q)) : 32'sd0;
    posvn_q <= (vn_q > 32'sd0) ? vn_q : 32'sd0;
    plim_q  <= mu_q * press_q;
  end

  always_comb begin
    gbf_pkg::wide_t npw;
    side_d = '0;
    for (int i = 0; i < 3; i++) begin
      npw            = gbf_pkg::rnd16(68'(pnp_q[i]));
      side_d.np[i]   = npw[34:0];
      side_d.t[i]    = gbf_pkg::sat32(68'(v_q[7][i]) - 68'(qnvn_q[i]));
      side_d.v[i]    = v_q[7][i];
      side_d.b[i]    = skip_q[7] ? 32'sd0 : b_q[7][i];
      if (skip_q[7]) begin
        side_d.alt[i] = vel_q[7][i];
      end else if (phipos_q[7]) begin
        side_d.alt[i] = mu_q[21] ? 32'sd0 : v_q[7][i];
      end else if (phineg_q[7]) begin
        side_d.alt[i] = gbf_pkg::sat32(gbf_pkg::rnd16(68'(pns_q[i])));
      end else begin
        side_d.alt[i] = v_q[7][i];
      end
    end
    side_d.lim     = gbf_pkg::sat32(gbf_pkg::rnd16(68'(plim_q)));
    side_d.fric    = !skip_q[7] && phipos_q[7] && !mu_q[21];
    side_d.touched = !skip_q[7];
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int j = 1; j < SideLen; j++) side_q[j] <= side_q[j-1];
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= $signed(side_q[0].t[i]) * $signed(side_q[0].t[i]);
    end
    len2_q <= $unsigned(sq_q[0]) + $unsigned(sq_q[1]) + $unsigned(sq_q[2]);
  end

  for (genvar k = 0; k < gbf_pkg::SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [63:0] BitV = 64'd1 << (62 - 2 * k);
    if (k == 0) begin : g_first
      assign sq_in[k] = {len2_q, 64'd0};
    end else begin : g_next
      assign sq_in[k] = sqs_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      sqs_q[k] <= gbf_pkg::sqrt_step(sq_in[k], BitV);
    end
  end

  always_comb begin
    logic [31:0] ts;
    logic [31:0] mag;
    logic [47:0] nn;
    for (int i = 0; i < 3; i++) begin
      ts            = side_q[34].t[i];
      mag           = ts[31] ? 32'(-ts) : ts;
      nn            = {mag, 16'd0} + {17'd0, sqs_q[31].r[31:1]};
      div_d[i].rem  = {1'b0, nn[47:17]};
      div_d[i].q    = '0;
      nlo_d[i]      = nn[16:0];
      negu_d[i]     = ts[31];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dv_q[0][i]  <= div_d[i];
      nlo_q[0][i] <= nlo_d[i];
    end
    d_q[0]    <= sqs_q[31].r[31:0];
    negu_q[0] <= negu_d;
    z_q[0]    <= sqs_q[31].r[31:0] == 32'd0;
    for (int k = 1; k < 18; k++) begin
      for (int i = 0; i < 3; i++) begin
        dv_q[k][i] <= gbf_pkg::div_step(dv_q[k-1][i], nlo_q[k-1][i][16], d_q[k-1]);
      end
      negu_q[k] <= negu_q[k-1];
      z_q[k]    <= z_q[k-1];
    end
    for (int k = 1; k < 17; k++) begin
      for (int i = 0; i < 3; i++) nlo_q[k][i] <= nlo_q[k-1][i] << 1;
      d_q[k] <= d_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [17:0] qs;
    logic signed [31:0] lim;
    logic signed [31:0] vsel;
    for (int i = 0; i < 3; i++) begin
      qs = $signed({1'b0, dv_q[17][i].q});
      if (z_q[17]) begin
        u_q[0][i] <= 18'sd0;
      end else begin
        u_q[0][i] <= negu_q[17][i] ? -qs : qs;
      end
      puv_q[i]  <= u_q[0][i] * $signed(side_q[53].v[i]);
      pufr_q[i] <= u_q[3][i] * fr_q;
      vnew_q[i] <= gbf_pkg::sat32(68'($signed(side_q[57].v[i]))
                   + 68'($signed(side_q[57].np[i]))
                   + gbf_pkg::rnd16(68'(pufr_q[i])));
      vsel      = side_q[58].fric ? vnew_q[i] : $signed(side_q[58].alt[i]);
      out_q[i]  <= gbf_pkg::sat32(68'(vsel) + 68'($signed(side_q[58].b[i])));
    end
    for (int j = 1; j < 4; j++) u_q[j] <= u_q[j-1];
    tv_q <= gbf_pkg::sat32(gbf_pkg::rnd16(68'(puv_q[0]) + 68'(puv_q[1]) + 68'(puv_q[2])));
    lim  = $signed(side_q[55].lim);
    if (tv_q > lim) begin
      fr_q <= -lim;
    end else if (tv_q < -lim) begin
      fr_q <= lim;
    end else begin
      fr_q <= -tv_q;
    end
    touched_q <= side_q[58].touched;
  end

endmodule

@@ src/gbf_checker.sv @@
// ----------------------------------------------------------------------------
// Boundary friction projection checker
// Port level timing and pass-through checks, bound to the core.
// ----------------------------------------------------------------------------
module gbf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [31:0] vel_x_i,
  input logic signed [31:0] phi_i,
  input logic signed [31:0] out_vel_x_o,
  input logic               touched_o
);

  localparam int Lat = gbf_pkg::LATENCY;

  logic take;
  logic in_band;

  assign take    = start && !busy;
  assign in_band = (phi_i <= gbf_pkg::PHI_HI) && (phi_i >= gbf_pkg::PHI_LO);

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##Lat done_o)
    else $error("result strobe missing after start transfer");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, Lat))
    else $error("result strobe without a matching start transfer");

  a_band_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_band |-> ##Lat touched_o)
    else $error("cell inside the band not marked touched");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !in_band |-> ##Lat (!touched_o && out_vel_x_o == $past(vel_x_i, Lat)))
    else $error("cell outside the band not passed through");

endmodule

bind grid_boundary_friction_projection_core gbf_checker u_gbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .vel_x_i     (vel_x_i),
  .phi_i       (phi_i),
  .out_vel_x_o (out_vel_x_o),
  .touched_o   (touched_o)
);
